// ===== sv/zebra_crossing_detector_defines.svh =====
// Assertion macros for the zebra crossing detector.
// Included by the top level; expects signals named clk and rst_n in scope.
`ifndef ZEBRA_CROSSING_DETECTOR_DEFINES_SVH
`define ZEBRA_CROSSING_DETECTOR_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ZCD_ASSERT_SAME(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ZCD_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/zcd_pkg.sv =====
`timescale 1ns / 1ps
// Types and constants of the zebra crossing detector.
// No dependencies; imported by zebra_crossing_detector.
package zcd_pkg;

    // Image geometry and run counter cap.
    localparam int IMAGE_WIDTH = 320;
    localparam int HALF_SPAN   = 150;
    localparam int RUN_CAP     = 20;

    localparam int COL_LO_RAW  = IMAGE_WIDTH / 2 - HALF_SPAN;
    localparam int COL_HI_RAW  = IMAGE_WIDTH / 2 + HALF_SPAN - 1;
    localparam int COL_LO_CLIP = (COL_LO_RAW < 0) ? 0 : COL_LO_RAW;
    localparam int COL_HI_CLIP = (COL_HI_RAW > 1023) ? 1023 : COL_HI_RAW;

    localparam logic [9:0] COL_FIRST = 10'(COL_LO_CLIP);
    localparam logic [9:0] COL_LAST  = 10'(COL_HI_CLIP);
    localparam logic [4:0] RUN_CAP_V = 5'(RUN_CAP);

    localparam logic [8:0]  BLOCKS_MAX = 9'h1FF;
    localparam logic [10:0] ROWS_MAX   = 11'h7FF;

    // Register map, word index into the configuration space.
    typedef enum logic [2:0] {
        REG_RUN_MIN       = 3'd0,
        REG_RUN_MAX       = 3'd1,
        REG_BLOCK_MIN     = 3'd2,
        REG_BLOCK_MAX     = 3'd3,
        REG_ROW_THRESHOLD = 3'd4,
        REG_STOP_FRAMES   = 3'd5,
        REG_ROW_FIRST     = 3'd6,
        REG_ROW_LAST      = 3'd7
    } reg_idx_t;

    localparam logic [4:0]  RST_RUN_MIN       = 5'd4;
    localparam logic [4:0]  RST_RUN_MAX       = 5'd8;
    localparam logic [8:0]  RST_BLOCK_MIN     = 9'd5;
    localparam logic [8:0]  RST_BLOCK_MAX     = 9'd9;
    localparam logic [10:0] RST_ROW_THRESHOLD = 11'd5;
    localparam logic [6:0]  RST_STOP_FRAMES   = 7'd10;
    localparam logic [9:0]  RST_ROW_FIRST     = 10'd70;
    localparam logic [9:0]  RST_ROW_LAST      = 10'd189;

    // Crossing phase.
    typedef enum logic [2:0] {
        PH_NONE   = 3'b001,
        PH_DETECT = 3'b010,
        PH_START  = 3'b100
    } phase_t;

    // Codes of the crossing_state result field.
    localparam logic [1:0] CS_NONE   = 2'd0;
    localparam logic [1:0] CS_DETECT = 2'd1;
    localparam logic [1:0] CS_START  = 2'd2;

    // Input item after the input register.
    typedef struct packed {
        logic [7:0] pixel;
        logic [9:0] col;
        logic [9:0] row;
        logic       frame_end;
    } pix_item_t;

    // Result item.
    typedef struct packed {
        logic [6:0]  countdown;
        logic [10:0] striped_rows;
        logic [1:0]  crossing_state;
        logic        detected;
    } result_t;

endpackage

// ===== sv/zebra_crossing_detector.sv =====
`timescale 1ns / 1ps
// Zebra crossing detector: counts black runs per row in a scan window of a raster stream.
// Depends on zcd_pkg and zebra_crossing_detector_defines.svh.
//
//   Channel   Direction  Handshake            Contents
//   s_*       in         s_tvalid / s_tready  pixel, col, row; s_tlast marks frame end
//   m_*       out        m_tvalid / m_tready  one result per frame
//   APB       in/out     psel, penable        eight configuration registers
//
// One pixel is taken per clock unless a stalled result holds the input stage; each item
// passes the input register, then the run, stripe and row counters update and a frame
// result lands in the output register, so a frame's last pixel passes both registers.
// Reset clears all counters and loads the register defaults. A stalled result holds the
// input stage only when the next item also ends a frame; other pixels keep flowing.
`include "zebra_crossing_detector_defines.svh"

module zebra_crossing_detector
    import zcd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // Stream in
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [7:0] pixel, [17:8] col, [27:18] row, [31:28] zero
    input  logic        s_tlast,   // frame_end
    // Stream out
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [0] detected, [2:1] crossing_state,
                                   // [13:3] striped_rows, [20:14] countdown, [23:21] zero
    // Configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // Configuration registers
    logic [4:0]  run_min_reg;
    logic [4:0]  run_max_reg;
    logic [8:0]  block_min_reg;
    logic [8:0]  block_max_reg;
    logic [10:0] row_threshold_reg;
    logic [6:0]  stop_frames_reg;
    logic [9:0]  row_first_reg;
    logic [9:0]  row_last_reg;

    reg_idx_t    cfg_idx;
    logic        cfg_wr;

    // Input stage
    logic        in_valid_reg;
    pix_item_t   in_item_reg;
    logic        in_adv;

    // Frame state
    logic [4:0]  run_length_reg, run_length_next;
    logic [8:0]  row_blocks_reg, row_blocks_next;
    logic [10:0] row_count_reg,  row_count_next;
    logic [6:0]  stop_count_reg, stop_count_next;
    phase_t      phase_reg,      phase_next;

    // Output stage
    logic        out_valid_reg;
    result_t     out_item_reg;
    result_t     out_item_next;

    // Per-pixel working values
    logic        in_win;
    logic        row_start;
    logic        row_end;
    logic [4:0]  run_base;
    logic [8:0]  blocks_base;
    logic [4:0]  run_upd;
    logic [8:0]  blocks_upd;
    logic [10:0] rows_upd;
    logic        stripe;
    logic        row_ok;
    logic        detected;
    phase_t      phase_det;
    logic [6:0]  stop_det;
    logic [1:0]  state_code;

    // ---------------- Configuration port ----------------
    assign pready  = 1'b1;
    assign cfg_idx = reg_idx_t'(paddr[4:2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_min_reg       <= RST_RUN_MIN;
            run_max_reg       <= RST_RUN_MAX;
            block_min_reg     <= RST_BLOCK_MIN;
            block_max_reg     <= RST_BLOCK_MAX;
            row_threshold_reg <= RST_ROW_THRESHOLD;
            stop_frames_reg   <= RST_STOP_FRAMES;
            row_first_reg     <= RST_ROW_FIRST;
            row_last_reg      <= RST_ROW_LAST;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                REG_RUN_MIN:       run_min_reg       <= pwdata[4:0];
                REG_RUN_MAX:       run_max_reg       <= pwdata[4:0];
                REG_BLOCK_MIN:     block_min_reg     <= pwdata[8:0];
                REG_BLOCK_MAX:     block_max_reg     <= pwdata[8:0];
                REG_ROW_THRESHOLD: row_threshold_reg <= pwdata[10:0];
                REG_STOP_FRAMES:   stop_frames_reg   <= pwdata[6:0];
                REG_ROW_FIRST:     row_first_reg     <= pwdata[9:0];
                REG_ROW_LAST:      row_last_reg      <= pwdata[9:0];
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            REG_RUN_MIN:       prdata = {27'd0, run_min_reg};
            REG_RUN_MAX:       prdata = {27'd0, run_max_reg};
            REG_BLOCK_MIN:     prdata = {23'd0, block_min_reg};
            REG_BLOCK_MAX:     prdata = {23'd0, block_max_reg};
            REG_ROW_THRESHOLD: prdata = {21'd0, row_threshold_reg};
            REG_STOP_FRAMES:   prdata = {25'd0, stop_frames_reg};
            REG_ROW_FIRST:     prdata = {22'd0, row_first_reg};
            REG_ROW_LAST:      prdata = {22'd0, row_last_reg};
            default:           prdata = 32'd0;
        endcase
    end

    // ---------------- Input register ----------------
    // The input stage moves on unless it holds a frame end and the result is stalled.
    assign in_adv   = in_valid_reg && (!in_item_reg.frame_end || !out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || in_adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_item_reg.pixel     <= s_tdata[7:0];
            in_item_reg.col       <= s_tdata[17:8];
            in_item_reg.row       <= s_tdata[27:18];
            in_item_reg.frame_end <= s_tlast;
        end
    end

    // ---------------- Run and row counting ----------------
    always_comb
    begin
        in_win = (in_item_reg.row >= row_first_reg) && (in_item_reg.row <= row_last_reg)
              && (in_item_reg.col >= COL_FIRST) && (in_item_reg.col <= COL_LAST);
        row_start = (in_item_reg.col == COL_FIRST);
        row_end   = (in_item_reg.col == COL_LAST);

        run_base    = row_start ? 5'd0 : run_length_reg;
        blocks_base = row_start ? 9'd0 : row_blocks_reg;

        // A nonzero pixel closes the run; it counts when its length is in range.
        stripe = (run_base >= run_min_reg) && (run_base <= run_max_reg)
              && (blocks_base != BLOCKS_MAX);

        if (in_item_reg.pixel == 8'd0)
        begin
            run_upd    = (run_base < RUN_CAP_V) ? run_base + 5'd1 : run_base;
            blocks_upd = blocks_base;
        end
        else
        begin
            run_upd    = 5'd0;
            blocks_upd = blocks_base + {8'd0, stripe};
        end

        row_ok = (blocks_upd >= block_min_reg) && (blocks_upd <= block_max_reg)
              && (row_count_reg != ROWS_MAX);

        rows_upd = row_count_reg;
        if (in_win && row_end)
        begin
            rows_upd   = row_count_reg + {10'd0, row_ok};
            run_upd    = 5'd0;
            blocks_upd = 9'd0;
        end
        if (!in_win)
        begin
            run_upd    = run_length_reg;
            blocks_upd = row_blocks_reg;
        end

        // Frame judgement.
        detected  = (rows_upd >= row_threshold_reg);
        phase_det = detected ? PH_DETECT : phase_reg;
        stop_det  = detected ? stop_frames_reg : stop_count_reg;
        phase_next      = phase_det;
        stop_count_next = stop_det;
        if ((phase_det == PH_DETECT) && (stop_det != 7'd0))
        begin
            stop_count_next = stop_det - 7'd1;
            if (stop_det == 7'd2)
            begin
                phase_next = PH_START;
            end
        end

        unique case (phase_next)
            PH_NONE:   state_code = CS_NONE;
            PH_DETECT: state_code = CS_DETECT;
            PH_START:  state_code = CS_START;
            default:   state_code = CS_NONE;
        endcase

        out_item_next.detected       = detected;
        out_item_next.crossing_state = state_code;
        out_item_next.striped_rows   = rows_upd;
        out_item_next.countdown      = stop_count_next;

        if (in_item_reg.frame_end)
        begin
            run_length_next = 5'd0;
            row_blocks_next = 9'd0;
            row_count_next  = 11'd0;
        end
        else
        begin
            run_length_next = run_upd;
            row_blocks_next = blocks_upd;
            row_count_next  = rows_upd;
            phase_next      = phase_reg;
            stop_count_next = stop_count_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_length_reg <= 5'd0;
            row_blocks_reg <= 9'd0;
            row_count_reg  <= 11'd0;
            stop_count_reg <= 7'd0;
            phase_reg      <= PH_NONE;
        end
        else if (in_adv)
        begin
            run_length_reg <= run_length_next;
            row_blocks_reg <= row_blocks_next;
            row_count_reg  <= row_count_next;
            stop_count_reg <= stop_count_next;
            phase_reg      <= phase_next;
        end
    end

    // ---------------- Output register ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_adv && in_item_reg.frame_end)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_adv && in_item_reg.frame_end)
        begin
            out_item_reg <= out_item_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'd0, out_item_reg};

    // ---------------- Assertions ----------------
    `ZCD_ASSERT_SAME(a_start_has_count_one,
        m_tvalid && (m_tdata[2:1] == CS_START), m_tdata[20:14] == 7'd1,
        "start phase reported with a countdown other than one")
    `ZCD_ASSERT_SAME(a_detect_sets_phase,
        m_tvalid && m_tdata[0], m_tdata[2:1] != CS_NONE,
        "detection reported while the phase is none")
    `ZCD_ASSERT_NEXT(a_input_stage_holds,
        in_valid_reg && !in_adv, in_valid_reg,
        "stalled input item was dropped")

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for zebra_crossing_detector: drives pixel items and APB writes,
// predicts each frame verdict in SystemVerilog (directed frames give theirs) and compares it with every result item.
// Depends on zcd_pkg and the zebra_crossing_detector RTL.
module tb;
    import zcd_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 400;
    localparam int DRAIN_CYCLES   = 4;
    localparam int NUM_SETTINGS   = 6;
    localparam int SETTING_ITEMS  = 60;
    localparam int SETTING_FRAMES = 2;

    typedef enum logic { ST_PIX, ST_CFG } step_kind_t;

    typedef struct {
        step_kind_t  kind;
        reg_idx_t    idx;
        logic [31:0] value;
        logic [7:0]  pixel;
        logic [9:0]  col;
        logic [9:0]  row;
        logic        fend;
        bit          typed;
        result_t     want;
    } dir_step_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;   // [7:0] pixel, [17:8] col, [27:18] row, [31:28] zero
    logic        s_tlast = 1'b0; // frame_end
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;        // [0] detected, [2:1] crossing_state,
                                 // [13:3] striped_rows, [20:14] countdown, [23:21] zero
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    // Shadow registers and counters of the predictor.
    logic [4:0]  cfg_run_min, cfg_run_max;
    logic [8:0]  cfg_block_min, cfg_block_max;
    logic [10:0] cfg_row_threshold;
    logic [6:0]  cfg_stop_frames;
    logic [9:0]  cfg_row_first, cfg_row_last;
    logic [4:0]  run_len;
    logic [8:0]  row_stripes;
    logic [10:0] striped_row_cnt;
    logic [6:0]  stop_cnt;
    logic [1:0]  crossing_ph;

    result_t     frame_results_q[$];
    dir_step_t   directed_q[$];

    int  errors = 0;
    int  pix_sent = 0;
    int  frames_sent = 0;
    int  crossings_seen = 0;
    int  setting_items = 0;
    int  setting_frames = 0;
    int  tx_idle_pct = 0;
    int  rx_stall_pct = 0;
    int  quiet_cycles = 0;
    int  hold_left = 0;
    bit  hold_go = 1'b0;
    bit  hold_done = 1'b0;

    zebra_crossing_detector dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Updates the shadow counters for one pixel item; returns 1 with the frame verdict
    // when the item ends a frame.
    function automatic bit crossing_step(input logic [7:0] pixel, input logic [9:0] col,
                                         input logic [9:0] row, input logic fend,
                                         output result_t verdict);
        bit hit;
        verdict = '0;
        if (row >= cfg_row_first && row <= cfg_row_last && col >= COL_FIRST && col <= COL_LAST)
        begin
            if (col == COL_FIRST)
            begin
                run_len     = '0;
                row_stripes = '0;
            end
            if (pixel == 8'd0)
            begin
                if (run_len < RUN_CAP_V)
                    run_len = run_len + 5'd1;
            end
            else
            begin
                if (run_len >= cfg_run_min && run_len <= cfg_run_max && row_stripes != BLOCKS_MAX)
                    row_stripes = row_stripes + 9'd1;
                run_len = '0;
            end
            // An open run at the row end is dropped without being counted.
            if (col == COL_LAST)
            begin
                if (row_stripes >= cfg_block_min && row_stripes <= cfg_block_max
                    && striped_row_cnt != ROWS_MAX)
                    striped_row_cnt = striped_row_cnt + 11'd1;
                run_len     = '0;
                row_stripes = '0;
            end
        end
        if (!fend)
            return 1'b0;
        hit = (striped_row_cnt >= cfg_row_threshold);
        if (hit)
        begin
            crossing_ph = CS_DETECT;
            stop_cnt    = cfg_stop_frames;
        end
        if (crossing_ph == CS_DETECT && stop_cnt != 7'd0)
        begin
            stop_cnt = stop_cnt - 7'd1;
            if (stop_cnt == 7'd1)
                crossing_ph = CS_START;
        end
        verdict.detected       = hit;
        verdict.crossing_state = crossing_ph;
        verdict.striped_rows   = striped_row_cnt;
        verdict.countdown      = stop_cnt;
        run_len         = '0;
        row_stripes     = '0;
        striped_row_cnt = '0;
        return 1'b1;
    endfunction

    function automatic logic [7:0] light_pixel();
        return 8'($urandom_range(255, 1));
    endfunction

    function automatic result_t frame_verdict(input logic det, input logic [1:0] cs,
                                              input int rows, input int cnt);
        result_t r;
        r.detected       = det;
        r.crossing_state = cs;
        r.striped_rows   = 11'(rows);
        r.countdown      = 7'(cnt);
        return r;
    endfunction

    function automatic dir_step_t pix_step(input logic [7:0] pixel, input logic [9:0] col,
                                           input logic [9:0] row, input logic fend);
        dir_step_t s;
        s = '{kind: ST_PIX, idx: REG_RUN_MIN, value: '0, pixel: pixel, col: col, row: row,
              fend: fend, typed: 1'b0, want: '0};
        return s;
    endfunction

    function automatic dir_step_t end_step(input logic [7:0] pixel, input logic [9:0] col,
                                           input logic [9:0] row, input result_t want);
        dir_step_t s;
        s       = pix_step(pixel, col, row, 1'b1);
        s.typed = 1'b1;
        s.want  = want;
        return s;
    endfunction

    function automatic dir_step_t cfg_step(input reg_idx_t idx, input int value);
        dir_step_t s;
        s       = pix_step('0, '0, '0, 1'b0);
        s.kind  = ST_CFG;
        s.idx   = idx;
        s.value = 32'(value);
        return s;
    endfunction

    task automatic send_pixel(input logic [7:0] pixel, input logic [9:0] col,
                              input logic [9:0] row, input logic fend,
                              input bit typed = 1'b0, input result_t want = '0);
        result_t verdict;
        @(negedge clk);
        while (tx_idle_pct > 0 && $urandom_range(99, 0) < tx_idle_pct)
        begin
            s_tvalid = 1'b0;
            @(negedge clk);
        end
        s_tdata  = {4'b0000, row, col, pixel};
        s_tlast  = fend;
        s_tvalid = 1'b1;
        do @(posedge clk); while (!s_tready);
        pix_sent++;
        setting_items++;
        if (crossing_step(pixel, col, row, fend, verdict))
        begin
            frame_results_q.push_back(typed ? want : verdict);
            frames_sent++;
            setting_frames++;
            if (verdict.detected)
                crossings_seen++;
        end
    endtask

    // Waits until every result is out and the pipeline has emptied.
    task automatic settle();
        @(negedge clk);
        s_tvalid = 1'b0;
        while (frame_results_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Writes one register, then reads it back.
    task automatic reg_write(input reg_idx_t idx, input logic [31:0] value);
        logic [31:0] kept;
        logic [31:0] rd;
        case (idx)
            REG_RUN_MIN:       begin cfg_run_min       = value[4:0];  kept = 32'(value[4:0]);  end
            REG_RUN_MAX:       begin cfg_run_max       = value[4:0];  kept = 32'(value[4:0]);  end
            REG_BLOCK_MIN:     begin cfg_block_min     = value[8:0];  kept = 32'(value[8:0]);  end
            REG_BLOCK_MAX:     begin cfg_block_max     = value[8:0];  kept = 32'(value[8:0]);  end
            REG_ROW_THRESHOLD: begin cfg_row_threshold = value[10:0]; kept = 32'(value[10:0]); end
            REG_STOP_FRAMES:   begin cfg_stop_frames   = value[6:0];  kept = 32'(value[6:0]);  end
            REG_ROW_FIRST:     begin cfg_row_first     = value[9:0];  kept = 32'(value[9:0]);  end
            default:           begin cfg_row_last      = value[9:0];  kept = 32'(value[9:0]);  end
        endcase
        @(negedge clk);
        s_tvalid = 1'b0;
        psel     = 1'b1;
        penable  = 1'b0;
        pwrite   = 1'b1;
        paddr    = {idx, 2'b00};
        pwdata   = value;
        @(negedge clk);
        penable = 1'b1;
        @(negedge clk);
        penable = 1'b0;
        pwrite  = 1'b0;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        rd = prdata;
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        if (rd !== kept)
        begin
            $display("%0t: register %s read back expected %0d got %0d", $realtime, idx.name(),
                     kept, rd);
            errors++;
        end
    endtask

    task automatic load_setting(input int sel);
        logic [4:0]  rmin, rmax;
        logic [8:0]  bmin, bmax;
        logic [10:0] thr;
        logic [6:0]  stop;
        logic [9:0]  rfirst, rlast;
        case (sel)
            1:
            begin
                // Everything qualifies and every frame reloads the longest countdown.
                rmin = 5'd0;  rmax = 5'd31; bmin = 9'd0; bmax = 9'd511;
                thr = 11'd0;  stop = 7'd127; rfirst = 10'd0; rlast = 10'd1023;
            end
            3:
            begin
                // Only saturated runs count, on the bottom row alone.
                rmin = 5'd20; rmax = 5'd31; bmin = 9'd1; bmax = 9'd2;
                thr = 11'd1024; stop = 7'd1; rfirst = 10'd1023; rlast = 10'd1023;
            end
            4:
            begin
                // Empty run, stripe and row windows.
                rmin = 5'd31; rmax = 5'd0; bmin = 9'd511; bmax = 9'd0;
                thr = 11'($urandom_range(1, 0)); stop = 7'd2; rfirst = 10'd600; rlast = 10'd599;
            end
            default:
            begin
                rmin   = 5'($urandom_range(3, 0));
                rmax   = rmin + 5'($urandom_range(3, 0));
                bmin   = 9'($urandom_range(2, 0));
                bmax   = bmin + 9'($urandom_range(2, 0));
                thr    = 11'($urandom_range(2, 0));
                stop   = 7'($urandom_range(6, 0));
                rfirst = 10'($urandom_range(1000, 0));
                rlast  = rfirst + 10'($urandom_range(23, 0));
            end
        endcase
        settle();
        reg_write(REG_RUN_MIN, 32'(rmin));
        reg_write(REG_RUN_MAX, 32'(rmax));
        reg_write(REG_BLOCK_MIN, 32'(bmin));
        reg_write(REG_BLOCK_MAX, 32'(bmax));
        reg_write(REG_ROW_THRESHOLD, 32'(thr));
        reg_write(REG_STOP_FRAMES, 32'(stop));
        reg_write(REG_ROW_FIRST, 32'(rfirst));
        reg_write(REG_ROW_LAST, 32'(rlast));
    endtask

    // One window row: a start pixel, black runs sized around the run window, and the
    // closing pixel, which is sometimes left out.
    task automatic send_row(input bit closes_frame);
        logic [9:0] r;
        int nblk, len, lo, run_lo, run_hi, b;
        bit broken;
        if (cfg_row_first <= cfg_row_last)
            r = 10'($urandom_range(int'(cfg_row_last), int'(cfg_row_first)));
        else
            r = 10'($urandom_range(1023, 0));
        broken = ($urandom_range(9, 0) == 0);
        run_lo = (cfg_run_min > 0) ? int'(cfg_run_min) - 1 : 0;
        run_hi = (cfg_run_max >= cfg_run_min) ? int'(cfg_run_max) + 1 : run_lo + 2;
        // An empty run window counts nothing, so short runs cover it.
        if (cfg_run_max < cfg_run_min)
        begin
            run_lo = 0;
            run_hi = 6;
        end
        if (run_hi > 24)
            run_hi = 24;
        lo   = (cfg_block_min > 4) ? 4 : int'(cfg_block_min);
        nblk = $urandom_range(lo + 2, lo);
        send_pixel($urandom_range(1, 0) ? 8'd0 : light_pixel(), COL_FIRST, r, 1'b0);
        for (b = 0; b < nblk; b++)
        begin
            if ($urandom_range(9, 0) == 0)
                len = $urandom_range(24, 0);
            else
                len = $urandom_range(run_hi, run_lo);
            repeat (len)
                send_pixel(8'd0, 10'($urandom_range(int'(COL_LAST) - 1, int'(COL_FIRST) + 1)),
                           r, 1'b0);
            send_pixel(light_pixel(),
                       10'($urandom_range(int'(COL_LAST) - 1, int'(COL_FIRST) + 1)), r, 1'b0);
        end
        if (!broken)
            send_pixel($urandom_range(1, 0) ? 8'd0 : light_pixel(), COL_LAST, r, closes_frame);
        else if (closes_frame)
            send_pixel(8'($urandom_range(255, 0)), 10'($urandom_range(1023, 0)),
                       10'($urandom_range(1023, 0)), 1'b1);
    endtask

    task automatic send_frame();
        int nrows, k;
        bit tail;
        nrows = $urandom_range(2, 0);
        tail  = (nrows == 0) || ($urandom_range(4, 0) == 0);
        for (k = 0; k < nrows; k++)
        begin
            if ($urandom_range(11, 0) == 0)
                send_pixel(8'($urandom_range(255, 0)), 10'($urandom_range(1023, 0)),
                           10'($urandom_range(1023, 0)), 1'b0);
            send_row(!tail && k == nrows - 1);
        end
        if (tail)
            send_pixel(8'($urandom_range(255, 0)), 10'($urandom_range(1023, 0)),
                       10'($urandom_range(1023, 0)), 1'b1);
    endtask

    // Receiver: one long hold-off when asked, otherwise random stalls when a stall rate is set.
    always @(negedge clk)
    begin
        if (hold_go && !hold_done)
        begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready = 1'b0;
        end
        else if (rx_stall_pct > 0)
            m_tready = ($urandom_range(99, 0) >= rx_stall_pct);
        else
            m_tready = 1'b1;
    end

    always @(posedge clk)
    begin
        result_t got, want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = result_t'(m_tdata[20:0]);
            if (frame_results_q.size() == 0)
            begin
                $display("%0t: result %h with none expected", $realtime, m_tdata);
                errors++;
            end
            else
            begin
                want = frame_results_q.pop_front();
                if (got.detected !== want.detected)
                begin
                    $display("%0t: detected expected %0d got %0d", $realtime,
                             want.detected, got.detected);
                    errors++;
                end
                if (got.crossing_state !== want.crossing_state)
                begin
                    $display("%0t: crossing_state expected %0d got %0d", $realtime,
                             want.crossing_state, got.crossing_state);
                    errors++;
                end
                if (got.striped_rows !== want.striped_rows)
                begin
                    $display("%0t: striped_rows expected %0d got %0d", $realtime,
                             want.striped_rows, got.striped_rows);
                    errors++;
                end
                if (got.countdown !== want.countdown)
                begin
                    $display("%0t: countdown expected %0d got %0d", $realtime,
                             want.countdown, got.countdown);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
            quiet_cycles = 0;
        else
            quiet_cycles = quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no item moved for %0d cycles", $realtime, WATCHDOG_LIMIT);
            $display("** zebra_crossing_detector: FAILED **");
            $finish;
        end
    end

    initial
    begin
        int sel;
        cfg_run_min       = RST_RUN_MIN;
        cfg_run_max       = RST_RUN_MAX;
        cfg_block_min     = RST_BLOCK_MIN;
        cfg_block_max     = RST_BLOCK_MAX;
        cfg_row_threshold = RST_ROW_THRESHOLD;
        cfg_stop_frames   = RST_STOP_FRAMES;
        cfg_row_first     = RST_ROW_FIRST;
        cfg_row_last      = RST_ROW_LAST;
        run_len           = '0;
        row_stripes       = '0;
        striped_row_cnt   = '0;
        stop_cnt          = '0;
        crossing_ph       = CS_NONE;

        // Defaults after reset, then a narrow run window with one stripe per row.
        directed_q.push_back(end_step(8'd255, 10'd0, 10'd0,
                                      frame_verdict(1'b0, CS_NONE, 0, 0)));
        directed_q.push_back(cfg_step(REG_RUN_MIN, 1));
        directed_q.push_back(cfg_step(REG_RUN_MAX, 2));
        directed_q.push_back(cfg_step(REG_BLOCK_MIN, 1));
        directed_q.push_back(cfg_step(REG_BLOCK_MAX, 1));
        directed_q.push_back(cfg_step(REG_ROW_THRESHOLD, 1));
        directed_q.push_back(cfg_step(REG_STOP_FRAMES, 3));
        // Qualifying row on the first window row; the frame ends outside the window.
        directed_q.push_back(pix_step(8'd0, COL_FIRST, 10'd70, 1'b0));
        directed_q.push_back(pix_step(8'd0, 10'd100, 10'd70, 1'b0));
        directed_q.push_back(pix_step(8'd7, 10'd150, 10'd70, 1'b0));
        directed_q.push_back(pix_step(8'd255, COL_LAST, 10'd70, 1'b0));
        directed_q.push_back(end_step(8'd0, 10'd1023, 10'd1023,
                                      frame_verdict(1'b1, CS_DETECT, 1, 2)));
        directed_q.push_back(end_step(8'd0, 10'd0, 10'd1023,
                                      frame_verdict(1'b0, CS_START, 0, 1)));
        directed_q.push_back(end_step(8'd128, 10'd512, 10'd512,
                                      frame_verdict(1'b0, CS_START, 0, 1)));
        // Last window row with a run left open, then rows just outside the window.
        directed_q.push_back(pix_step(8'd0, COL_FIRST, 10'd189, 1'b0));
        directed_q.push_back(pix_step(8'd0, COL_LAST, 10'd189, 1'b0));
        directed_q.push_back(pix_step(8'd0, COL_FIRST, 10'd190, 1'b0));
        directed_q.push_back(pix_step(8'd1, COL_LAST, 10'd69, 1'b0));
        // Row closed by the frame end pixel itself.
        directed_q.push_back(pix_step(8'd0, COL_FIRST, 10'd100, 1'b0));
        directed_q.push_back(pix_step(8'd9, 10'd200, 10'd100, 1'b0));
        directed_q.push_back(end_step(8'd0, COL_LAST, 10'd100,
                                      frame_verdict(1'b1, CS_DETECT, 1, 2)));
        // Two stripes in one row exceed the stripe window.
        directed_q.push_back(pix_step(8'd0, COL_FIRST, 10'd120, 1'b0));
        directed_q.push_back(pix_step(8'd3, 10'd11, 10'd120, 1'b0));
        directed_q.push_back(pix_step(8'd0, 10'd12, 10'd120, 1'b0));
        directed_q.push_back(pix_step(8'd0, 10'd13, 10'd120, 1'b0));
        directed_q.push_back(end_step(8'd4, COL_LAST, 10'd120,
                                      frame_verdict(1'b0, CS_START, 0, 1)));
        // A countdown of one runs down to zero and stays in detection.
        directed_q.push_back(cfg_step(REG_STOP_FRAMES, 1));
        directed_q.push_back(pix_step(8'd0, COL_FIRST, 10'd150, 1'b0));
        directed_q.push_back(end_step(8'd1, COL_LAST, 10'd150,
                                      frame_verdict(1'b1, CS_DETECT, 1, 0)));
        // A countdown of zero with a zero row threshold.
        directed_q.push_back(cfg_step(REG_STOP_FRAMES, 0));
        directed_q.push_back(cfg_step(REG_ROW_THRESHOLD, 0));
        directed_q.push_back(end_step(8'd200, 10'd5, 10'd5,
                                      frame_verdict(1'b1, CS_DETECT, 0, 0)));
        // Run window empty: nothing can count as a stripe.
        directed_q.push_back(cfg_step(REG_RUN_MIN, 3));
        directed_q.push_back(cfg_step(REG_ROW_THRESHOLD, 1));
        directed_q.push_back(pix_step(8'd0, COL_FIRST, 10'd160, 1'b0));
        directed_q.push_back(end_step(8'd1, COL_LAST, 10'd160,
                                      frame_verdict(1'b0, CS_DETECT, 0, 0)));

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (directed_q[i])
        begin
            if (directed_q[i].kind == ST_CFG)
            begin
                settle();
                reg_write(directed_q[i].idx, directed_q[i].value);
            end
            else
                send_pixel(directed_q[i].pixel, directed_q[i].col, directed_q[i].row,
                           directed_q[i].fend, directed_q[i].typed, directed_q[i].want);
        end

        for (sel = 0; sel < NUM_SETTINGS; sel++)
        begin
            load_setting(sel);
            case (sel % 4)
                0:       begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1:       begin tx_idle_pct = 61; rx_stall_pct = 0;  end
                2:       begin tx_idle_pct = 0;  rx_stall_pct = 61; end
                default: begin tx_idle_pct = 30; rx_stall_pct = 30; end
            endcase
            // The receiver holds off while items keep coming, so the block backs up.
            if (sel == 0)
                hold_go = 1'b1;
            setting_items  = 0;
            setting_frames = 0;
            while (setting_items < SETTING_ITEMS || setting_frames < SETTING_FRAMES)
                send_frame();
        end

        settle();
        $display("Run covered %0d pixel items in %0d frames, %0d of them crossings, over %0d",
                 pix_sent, frames_sent, crossings_seen, NUM_SETTINGS + 1);
        $display("register settings with idle sender, stalled receiver and a long hold-off.");
        if (errors == 0 && frame_results_q.size() == 0)
            $display("** zebra_crossing_detector: PASSED **");
        else
            $display("** zebra_crossing_detector: FAILED **");
        $finish;
    end

endmodule

// ===== zebra_crossing_detector.f =====
+incdir+sv
sv/zcd_pkg.sv
sv/zebra_crossing_detector.sv
dv/tb.sv
